>>> hw/rtl/imu_tilt_pkg.sv
// ============================================================================
// imu tilt estimator package
// shared widths, register indexes, state types and the cordic arctangent table
// ============================================================================
package imu_tilt_pkg;

    // field widths
    localparam int SAMPLE_W  = 16;
    localparam int GAIN_W    = 16;
    localparam int ANGLE_W   = 16;
    localparam int GYRO_W    = 32;
    localparam int CFG_IDX_W = 4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_GAIN = CFG_IDX_W'(1);

    // gyro mode codes
    localparam logic GYRO_MODE_INTEGRATE = 1'b0;
    localparam logic GYRO_MODE_RATE      = 1'b1;

    // register reset values
    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(3996);

    // cordic datapath
    localparam int ATAN_LEN = 24;
    localparam int STEP_W   = 5;
    localparam int ATAN_W   = 23;
    localparam int VEC_W    = 27;
    localparam logic signed [VEC_W-1:0] HALF_TURN   = VEC_W'(11796480);
    localparam logic signed [VEC_W-1:0] ROUND_HALF  = VEC_W'(256);
    localparam logic signed [VEC_W-1:0] ANGLE_LIMIT = VEC_W'(23040);

    // gyro datapath
    localparam int NUM_AXES = 3;
    localparam int AXIS_W   = 2;
    localparam int PROD_W   = 33;
    localparam int GYRO_SHIFT = 9;

    typedef enum logic [1:0] {
        CORD_IDLE,
        CORD_RUN,
        CORD_FIN
    } cordic_state_t;

    typedef enum logic [1:0] {
        GYR_IDLE,
        GYR_MUL,
        GYR_ADD
    } gyro_state_t;

    typedef enum logic [1:0] {
        TOP_IDLE,
        TOP_ROLL,
        TOP_PITCH,
        TOP_PUSH
    } top_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_status_t;

    // atan(2^-i) in 2^-16 degree, rounded to nearest
    function automatic logic [ATAN_W-1:0] atan_entry(input logic [STEP_W-1:0] idx);
        logic [ATAN_W-1:0] val;
        case (idx)
            5'd0:    val = ATAN_W'(2949120);
            5'd1:    val = ATAN_W'(1740967);
            5'd2:    val = ATAN_W'(919879);
            5'd3:    val = ATAN_W'(466945);
            5'd4:    val = ATAN_W'(234379);
            5'd5:    val = ATAN_W'(117304);
            5'd6:    val = ATAN_W'(58666);
            5'd7:    val = ATAN_W'(29335);
            5'd8:    val = ATAN_W'(14668);
            5'd9:    val = ATAN_W'(7334);
            5'd10:   val = ATAN_W'(3667);
            5'd11:   val = ATAN_W'(1833);
            5'd12:   val = ATAN_W'(917);
            5'd13:   val = ATAN_W'(458);
            5'd14:   val = ATAN_W'(229);
            5'd15:   val = ATAN_W'(115);
            5'd16:   val = ATAN_W'(57);
            5'd17:   val = ATAN_W'(29);
            5'd18:   val = ATAN_W'(14);
            5'd19:   val = ATAN_W'(7);
            5'd20:   val = ATAN_W'(4);
            5'd21:   val = ATAN_W'(2);
            5'd22:   val = ATAN_W'(1);
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

>>> hw/rtl/imu_tilt_cordic.sv
// ============================================================================
// imu tilt cordic engine
// iterative vectoring cordic, one micro-rotation per cycle, gives atan2(num, den)
// ============================================================================
module imu_tilt_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         start,
    input  logic signed [imu_tilt_pkg::SAMPLE_W-1:0]     num,
    input  logic signed [imu_tilt_pkg::SAMPLE_W-1:0]     den,
    output imu_tilt_pkg::unit_status_t                   status,
    output logic signed [imu_tilt_pkg::ANGLE_W-1:0]      angle
);

    localparam int NUM_ITER = (CORDIC_STEPS < imu_tilt_pkg::ATAN_LEN) ?
                              CORDIC_STEPS : imu_tilt_pkg::ATAN_LEN;
    localparam logic [imu_tilt_pkg::STEP_W-1:0] LAST_IDX =
        imu_tilt_pkg::STEP_W'(NUM_ITER - 1);

    imu_tilt_pkg::cordic_state_t state_reg, state_next;
    logic [imu_tilt_pkg::STEP_W-1:0] idx_reg, idx_next;

    logic signed [imu_tilt_pkg::VEC_W-1:0] x_reg, x_next;
    logic signed [imu_tilt_pkg::VEC_W-1:0] y_reg, y_next;
    logic signed [imu_tilt_pkg::VEC_W-1:0] z_reg, z_next;
    logic zero_reg, zero_next;

    logic signed [imu_tilt_pkg::VEC_W-1:0] num_ext, den_ext;
    logic signed [imu_tilt_pkg::VEC_W-1:0] x_shift, y_shift, step_angle;
    logic signed [imu_tilt_pkg::VEC_W-1:0] z_round, z_scaled, z_clamped;
    logic load;

    // operands scaled by 2^8
    assign num_ext = imu_tilt_pkg::VEC_W'(num) <<< 8;
    assign den_ext = imu_tilt_pkg::VEC_W'(den) <<< 8;

    // shared micro-rotation operands
    assign x_shift    = x_reg >>> idx_reg;
    assign y_shift    = y_reg >>> idx_reg;
    assign step_angle = signed'({{(imu_tilt_pkg::VEC_W - imu_tilt_pkg::ATAN_W){1'b0}},
                                 imu_tilt_pkg::atan_entry(idx_reg)});

    assign load = start && (state_reg != imu_tilt_pkg::CORD_RUN);

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= imu_tilt_pkg::CORD_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            imu_tilt_pkg::CORD_IDLE,
            imu_tilt_pkg::CORD_FIN:
            begin
                idx_next = '0;
                if (load)
                    state_next = imu_tilt_pkg::CORD_RUN;
                else
                    state_next = imu_tilt_pkg::CORD_IDLE;
            end
            imu_tilt_pkg::CORD_RUN:
            begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == LAST_IDX)
                    state_next = imu_tilt_pkg::CORD_FIN;
            end
            default:
            begin
                state_next = imu_tilt_pkg::CORD_IDLE;
            end
        endcase
        status.busy = (state_reg == imu_tilt_pkg::CORD_RUN);
        status.done = (state_reg == imu_tilt_pkg::CORD_FIN);
    end

    // vector and angle datapath
    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        zero_next = zero_reg;
        if (load)
        begin
            zero_next = (num == '0) && (den == '0);
            if (den_ext < 0)
            begin
                x_next = -den_ext;
                y_next = -num_ext;
                z_next = (num_ext >= 0) ? imu_tilt_pkg::HALF_TURN : -imu_tilt_pkg::HALF_TURN;
            end
            else
            begin
                x_next = den_ext;
                y_next = num_ext;
                z_next = '0;
            end
        end
        else if (state_reg == imu_tilt_pkg::CORD_RUN)
        begin
            if (y_reg > 0)
            begin
                x_next = x_reg + y_shift;
                y_next = y_reg - x_shift;
                z_next = z_reg + step_angle;
            end
            else
            begin
                x_next = x_reg - y_shift;
                y_next = y_reg + x_shift;
                z_next = z_reg - step_angle;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        zero_reg <= zero_next;
    end

    // round to 1/128 degree and clamp
    always_comb
    begin
        z_round  = z_reg + imu_tilt_pkg::ROUND_HALF;
        z_scaled = z_round >>> 9;
        if (z_scaled > imu_tilt_pkg::ANGLE_LIMIT)
            z_clamped = imu_tilt_pkg::ANGLE_LIMIT;
        else if (z_scaled < -imu_tilt_pkg::ANGLE_LIMIT)
            z_clamped = -imu_tilt_pkg::ANGLE_LIMIT;
        else
            z_clamped = z_scaled;
        angle = zero_reg ? '0 : imu_tilt_pkg::ANGLE_W'(z_clamped);
    end

endmodule

>>> hw/rtl/imu_tilt_gyro.sv
// ============================================================================
// imu tilt gyro unit
// one shared multiplier and saturating adder, stepped over the three axes
// ============================================================================
module imu_tilt_gyro (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         start,
    input  logic                                         mode,
    input  logic [imu_tilt_pkg::GAIN_W-1:0]              gain,
    input  logic signed [imu_tilt_pkg::SAMPLE_W-1:0]     raw [imu_tilt_pkg::NUM_AXES],
    output imu_tilt_pkg::unit_status_t                   status,
    output logic signed [imu_tilt_pkg::GYRO_W-1:0]       result [imu_tilt_pkg::NUM_AXES]
);

    localparam logic [imu_tilt_pkg::AXIS_W-1:0] LAST_AXIS =
        imu_tilt_pkg::AXIS_W'(imu_tilt_pkg::NUM_AXES - 1);
    localparam logic signed [imu_tilt_pkg::PROD_W-1:0] SAT_MAX =
        imu_tilt_pkg::PROD_W'(33'sh0_7FFF_FFFF);
    localparam logic signed [imu_tilt_pkg::PROD_W-1:0] SAT_MIN =
        imu_tilt_pkg::PROD_W'(33'sh1_8000_0000);

    imu_tilt_pkg::gyro_state_t state_reg, state_next;
    logic [imu_tilt_pkg::AXIS_W-1:0] axis_reg, axis_next;
    logic mode_reg;

    logic signed [imu_tilt_pkg::SAMPLE_W-1:0] raw_reg [imu_tilt_pkg::NUM_AXES];
    logic signed [imu_tilt_pkg::PROD_W-1:0]   prod_reg;
    logic signed [imu_tilt_pkg::GYRO_W-1:0]   acc_reg [imu_tilt_pkg::NUM_AXES];
    logic signed [imu_tilt_pkg::GYRO_W-1:0]   res_reg [imu_tilt_pkg::NUM_AXES];

    logic signed [imu_tilt_pkg::PROD_W-1:0] prod_next, prod_shift, sum_wide;
    logic signed [imu_tilt_pkg::GYRO_W-1:0] term, sat_sum;
    logic load;

    assign load = start && (state_reg == imu_tilt_pkg::GYR_IDLE);

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= imu_tilt_pkg::GYR_IDLE;
            axis_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        unique case (state_reg)
            imu_tilt_pkg::GYR_IDLE:
            begin
                axis_next = '0;
                if (load)
                    state_next = imu_tilt_pkg::GYR_MUL;
            end
            imu_tilt_pkg::GYR_MUL:
            begin
                state_next = imu_tilt_pkg::GYR_ADD;
            end
            imu_tilt_pkg::GYR_ADD:
            begin
                if (axis_reg == LAST_AXIS)
                begin
                    state_next = imu_tilt_pkg::GYR_IDLE;
                end
                else
                begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = imu_tilt_pkg::GYR_MUL;
                end
            end
            default:
            begin
                state_next = imu_tilt_pkg::GYR_IDLE;
            end
        endcase
        status.busy = (state_reg != imu_tilt_pkg::GYR_IDLE);
        status.done = (state_reg == imu_tilt_pkg::GYR_ADD) && (axis_reg == LAST_AXIS);
    end

    // shared multiplier and saturating adder
    always_comb
    begin
        prod_next  = imu_tilt_pkg::PROD_W'(raw_reg[axis_reg]) *
                     signed'(imu_tilt_pkg::PROD_W'({1'b0, gain}));
        prod_shift = prod_reg >>> imu_tilt_pkg::GYRO_SHIFT;
        term       = imu_tilt_pkg::GYRO_W'(prod_shift);
        sum_wide   = imu_tilt_pkg::PROD_W'(acc_reg[axis_reg]) + imu_tilt_pkg::PROD_W'(term);
        if (sum_wide > SAT_MAX)
            sat_sum = imu_tilt_pkg::GYRO_W'(SAT_MAX);
        else if (sum_wide < SAT_MIN)
            sat_sum = imu_tilt_pkg::GYRO_W'(SAT_MIN);
        else
            sat_sum = imu_tilt_pkg::GYRO_W'(sum_wide);
    end

    // sample capture, product and results
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mode_reg <= mode;
            for (int k = 0; k < imu_tilt_pkg::NUM_AXES; k++)
            begin
                raw_reg[k] <= raw[k];
            end
        end
        if (state_reg == imu_tilt_pkg::GYR_MUL)
            prod_reg <= prod_next;
        if (state_reg == imu_tilt_pkg::GYR_ADD)
        begin
            if (mode_reg == imu_tilt_pkg::GYRO_MODE_INTEGRATE)
                res_reg[axis_reg] <= sat_sum;
            else
                res_reg[axis_reg] <= term;
        end
    end

    // angle accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < imu_tilt_pkg::NUM_AXES; k++)
            begin
                acc_reg[k] <= '0;
            end
        end
        else if ((state_reg == imu_tilt_pkg::GYR_ADD) &&
                 (mode_reg == imu_tilt_pkg::GYRO_MODE_INTEGRATE))
        begin
            acc_reg[axis_reg] <= sat_sum;
        end
    end

    assign result = res_reg;

endmodule

>>> hw/rtl/imu_tilt_angle_estimator_unit.sv
// ============================================================================
// imu tilt angle estimator
// accelerometer roll and pitch by cordic atan2, gyro rate scaling and integration
// ============================================================================
// Usage:
//   Input channel: in_valid / in_stall carry one beat of six signed 16-bit
//   samples (accel_x/y/z, gyro_x/y/z). in_stall is high while a sample is in
//   work, so one beat is taken at a time.
//   Output channel: out_valid / out_stall carry one beat per input beat:
//   accel_roll, accel_pitch (1/128 degree) and gyro_roll/pitch/yaw.
//   Config channel: cfg_valid / cfg_ready with cfg_index and cfg_data;
//   index 0 is gyro_mode, 1 is gyro_gain, other indexes are ignored.
//   cfg_ready is always high; write only while the block is idle.
// Operation:
//   each angle takes N = min(CORDIC_STEPS, 24) cordic micro-rotations; the
//   roll and pitch run one after the other on the one cordic engine, the
//   gyro axes run one after another on a shared multiplier alongside the
//   cordic. A new beat is taken in the cycle after the result is loaded.
// Reset: clears the gyro accumulators, sets gyro_mode 0 and gyro_gain 3996.
// A stalled result holds in the output register; the next result waits
// for it to be taken before it is loaded.
// ============================================================================
module imu_tilt_angle_estimator_unit #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    // sample input
    input  logic                                          in_valid,
    output logic                                          in_stall,
    input  logic signed [imu_tilt_pkg::SAMPLE_W-1:0]      accel_x,
    input  logic signed [imu_tilt_pkg::SAMPLE_W-1:0]      accel_y,
    input  logic signed [imu_tilt_pkg::SAMPLE_W-1:0]      accel_z,
    input  logic signed [imu_tilt_pkg::SAMPLE_W-1:0]      gyro_x,
    input  logic signed [imu_tilt_pkg::SAMPLE_W-1:0]      gyro_y,
    input  logic signed [imu_tilt_pkg::SAMPLE_W-1:0]      gyro_z,
    // result output
    output logic                                          out_valid,
    input  logic                                          out_stall,
    output logic signed [imu_tilt_pkg::ANGLE_W-1:0]       accel_roll,
    output logic signed [imu_tilt_pkg::ANGLE_W-1:0]       accel_pitch,
    output logic signed [imu_tilt_pkg::GYRO_W-1:0]        gyro_roll,
    output logic signed [imu_tilt_pkg::GYRO_W-1:0]        gyro_pitch,
    output logic signed [imu_tilt_pkg::GYRO_W-1:0]        gyro_yaw,
    // configuration writes
    input  logic                                          cfg_valid,
    output logic                                          cfg_ready,
    input  logic [imu_tilt_pkg::CFG_IDX_W-1:0]            cfg_index,
    input  logic [imu_tilt_pkg::GAIN_W-1:0]               cfg_data
);

    imu_tilt_pkg::top_state_t state_reg, state_next;

    logic gyro_mode_reg;
    logic [imu_tilt_pkg::GAIN_W-1:0] gyro_gain_reg;

    logic signed [imu_tilt_pkg::SAMPLE_W-1:0] ax_reg, az_reg;
    logic signed [imu_tilt_pkg::ANGLE_W-1:0]  roll_reg;

    logic out_valid_reg, out_valid_next;
    logic signed [imu_tilt_pkg::ANGLE_W-1:0] out_roll_reg, out_pitch_reg;
    logic signed [imu_tilt_pkg::GYRO_W-1:0]  out_groll_reg, out_gpitch_reg, out_gyaw_reg;

    logic in_accept, push_load;
    logic cord_start;
    logic signed [imu_tilt_pkg::SAMPLE_W-1:0] cord_num, cord_den;
    logic signed [imu_tilt_pkg::ANGLE_W-1:0]  cord_angle;
    imu_tilt_pkg::unit_status_t cord_status, gyro_status;

    logic signed [imu_tilt_pkg::SAMPLE_W-1:0] gyro_raw [imu_tilt_pkg::NUM_AXES];
    logic signed [imu_tilt_pkg::GYRO_W-1:0]   gyro_res [imu_tilt_pkg::NUM_AXES];

    assign in_stall  = (state_reg != imu_tilt_pkg::TOP_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign gyro_raw[0] = gyro_x;
    assign gyro_raw[1] = gyro_y;
    assign gyro_raw[2] = gyro_z;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gyro_mode_reg <= imu_tilt_pkg::GYRO_MODE_INTEGRATE;
            gyro_gain_reg <= imu_tilt_pkg::GAIN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                imu_tilt_pkg::CFG_IDX_MODE: gyro_mode_reg <= cfg_data[0];
                imu_tilt_pkg::CFG_IDX_GAIN: gyro_gain_reg <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // shared cordic engine, roll then pitch
    imu_tilt_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cord_start),
        .num    (cord_num),
        .den    (cord_den),
        .status (cord_status),
        .angle  (cord_angle)
    );

    // gyro scaling and integration
    imu_tilt_gyro u_gyro (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (in_accept),
        .mode   (gyro_mode_reg),
        .gain   (gyro_gain_reg),
        .raw    (gyro_raw),
        .status (gyro_status),
        .result (gyro_res)
    );

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= imu_tilt_pkg::TOP_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cord_start = 1'b0;
        cord_num   = ax_reg;
        cord_den   = az_reg;
        push_load  = 1'b0;
        unique case (state_reg)
            imu_tilt_pkg::TOP_IDLE:
            begin
                cord_num = accel_y;
                cord_den = accel_z;
                if (in_accept)
                begin
                    cord_start = 1'b1;
                    state_next = imu_tilt_pkg::TOP_ROLL;
                end
            end
            imu_tilt_pkg::TOP_ROLL:
            begin
                if (cord_status.done)
                begin
                    cord_start = 1'b1;
                    state_next = imu_tilt_pkg::TOP_PITCH;
                end
            end
            imu_tilt_pkg::TOP_PITCH:
            begin
                if (cord_status.done)
                    state_next = imu_tilt_pkg::TOP_PUSH;
            end
            imu_tilt_pkg::TOP_PUSH:
            begin
                if (!gyro_status.busy && (!out_valid_reg || !out_stall))
                begin
                    push_load  = 1'b1;
                    state_next = imu_tilt_pkg::TOP_IDLE;
                end
            end
            default:
            begin
                state_next = imu_tilt_pkg::TOP_IDLE;
            end
        endcase
        out_valid_next = push_load || (out_valid_reg && out_stall);
    end

    // sample capture and result register
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            ax_reg <= accel_x;
            az_reg <= accel_z;
        end
        if ((state_reg == imu_tilt_pkg::TOP_ROLL) && cord_status.done)
            roll_reg <= cord_angle;
        if ((state_reg == imu_tilt_pkg::TOP_PITCH) && cord_status.done)
            out_pitch_reg <= cord_angle;
        if (push_load)
        begin
            out_roll_reg   <= roll_reg;
            out_groll_reg  <= gyro_res[0];
            out_gpitch_reg <= gyro_res[1];
            out_gyaw_reg   <= gyro_res[2];
        end
    end

    // pitch is staged in out_pitch_reg ahead of the push, so a hold register drives the output
    logic signed [imu_tilt_pkg::ANGLE_W-1:0] out_pitch_hold_reg;

    always_ff @(posedge clk)
    begin
        if (push_load)
            out_pitch_hold_reg <= out_pitch_reg;
    end

    assign out_valid   = out_valid_reg;
    assign accel_roll  = out_roll_reg;
    assign accel_pitch = out_pitch_hold_reg;
    assign gyro_roll   = out_groll_reg;
    assign gyro_pitch  = out_gpitch_reg;
    assign gyro_yaw    = out_gyaw_reg;

endmodule

>>> tb/sv/tilt_result_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// tilt result checker
// watches the sample, result and register channels of the tilt estimator,
// predicts each result beat from its own model of the cordic and the gyro
// path, and compares it field by field with what the block returns
// ============================================================================
module tilt_result_checker #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_valid,
    input  logic                                      in_stall,
    input  logic signed [imu_tilt_pkg::SAMPLE_W-1:0]  accel_x,
    input  logic signed [imu_tilt_pkg::SAMPLE_W-1:0]  accel_y,
    input  logic signed [imu_tilt_pkg::SAMPLE_W-1:0]  accel_z,
    input  logic signed [imu_tilt_pkg::SAMPLE_W-1:0]  gyro_x,
    input  logic signed [imu_tilt_pkg::SAMPLE_W-1:0]  gyro_y,
    input  logic signed [imu_tilt_pkg::SAMPLE_W-1:0]  gyro_z,
    input  logic                                      out_valid,
    input  logic                                      out_stall,
    input  logic signed [imu_tilt_pkg::ANGLE_W-1:0]   accel_roll,
    input  logic signed [imu_tilt_pkg::ANGLE_W-1:0]   accel_pitch,
    input  logic signed [imu_tilt_pkg::GYRO_W-1:0]    gyro_roll,
    input  logic signed [imu_tilt_pkg::GYRO_W-1:0]    gyro_pitch,
    input  logic signed [imu_tilt_pkg::GYRO_W-1:0]    gyro_yaw,
    input  logic                                      cfg_valid,
    input  logic                                      cfg_ready,
    input  logic [imu_tilt_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [imu_tilt_pkg::GAIN_W-1:0]           cfg_data,
    output int                                        mismatch_count,
    output int                                        tilt_pending
);

    localparam int     ROT_STEPS     = (CORDIC_STEPS < imu_tilt_pkg::ATAN_LEN) ?
                                       CORDIC_STEPS : imu_tilt_pkg::ATAN_LEN;
    localparam longint HALF_TURN_Q16 = 11796480;
    localparam longint ANGLE_CLAMP   = 23040;
    localparam longint ACC_MAX       = 64'sh7fffffff;
    localparam longint ACC_MIN       = -64'sh80000000;

    typedef struct {
        logic signed [imu_tilt_pkg::ANGLE_W-1:0] roll;
        logic signed [imu_tilt_pkg::ANGLE_W-1:0] pitch;
        logic signed [imu_tilt_pkg::GYRO_W-1:0]  rate_x;
        logic signed [imu_tilt_pkg::GYRO_W-1:0]  rate_y;
        logic signed [imu_tilt_pkg::GYRO_W-1:0]  rate_z;
    } tilt_result_t;

    tilt_result_t                           expected_tilt[$];
    logic                                   mode_q;
    logic [imu_tilt_pkg::GAIN_W-1:0]        gain_q;
    logic signed [imu_tilt_pkg::GYRO_W-1:0] axis_angle [3];
    int                                     errs;

    // rotation angle of step k, atan(2^-k) in 2^-16 degree
    function automatic longint rot_angle(input int k);
        case (k)
            0:  return 2949120;
            1:  return 1740967;
            2:  return 919879;
            3:  return 466945;
            4:  return 234379;
            5:  return 117304;
            6:  return 58666;
            7:  return 29335;
            8:  return 14668;
            9:  return 7334;
            10: return 3667;
            11: return 1833;
            12: return 917;
            13: return 458;
            14: return 229;
            15: return 115;
            16: return 57;
            17: return 29;
            18: return 14;
            19: return 7;
            20: return 4;
            21: return 2;
            22: return 1;
            default: return 0;
        endcase
    endfunction

    // vectoring cordic, angle of (den, num) in 1/128 degree
    function automatic logic signed [imu_tilt_pkg::ANGLE_W-1:0] vector_angle(
        input logic signed [imu_tilt_pkg::SAMPLE_W-1:0] num,
        input logic signed [imu_tilt_pkg::SAMPLE_W-1:0] den
    );
        longint x, y, z, nx, ny;
        int     k;
        if (num == 0 && den == 0)
            return '0;
        x = longint'(den) * 256;
        y = longint'(num) * 256;
        z = 0;
        // left half plane: fold over and start from a half turn
        if (x < 0)
        begin
            z = (y >= 0) ? HALF_TURN_Q16 : -HALF_TURN_Q16;
            x = -x;
            y = -y;
        end
        for (k = 0; k < ROT_STEPS; k++)
        begin
            if (y > 0)
            begin
                nx = x + (y >>> k);
                ny = y - (x >>> k);
                z  = z + rot_angle(k);
            end
            else
            begin
                nx = x - (y >>> k);
                ny = y + (x >>> k);
                z  = z - rot_angle(k);
            end
            x = nx;
            y = ny;
        end
        z = (z + 256) >>> 9;
        if (z > ANGLE_CLAMP)
            z = ANGLE_CLAMP;
        if (z < -ANGLE_CLAMP)
            z = -ANGLE_CLAMP;
        return imu_tilt_pkg::ANGLE_W'(z);
    endfunction

    // scaled gyro rate, floor of raw * gain / 512
    function automatic longint rate_term(input logic signed [imu_tilt_pkg::SAMPLE_W-1:0] raw);
        longint prod;
        prod = longint'(raw) * longint'(gain_q);
        return prod >>> imu_tilt_pkg::GYRO_SHIFT;
    endfunction

    // one accepted sample: angles, and either new integrated angles or rates
    function automatic tilt_result_t predict_tilt(
        input logic signed [imu_tilt_pkg::SAMPLE_W-1:0] ax, ay, az, gx, gy, gz
    );
        tilt_result_t                           r;
        longint                                 term [3];
        longint                                 s;
        logic signed [imu_tilt_pkg::GYRO_W-1:0] word [3];
        int                                     a;
        r.roll  = vector_angle(ay, az);
        r.pitch = vector_angle(ax, az);
        term[0] = rate_term(gx);
        term[1] = rate_term(gy);
        term[2] = rate_term(gz);
        for (a = 0; a < 3; a++)
        begin
            if (mode_q == imu_tilt_pkg::GYRO_MODE_INTEGRATE)
            begin
                s = longint'(axis_angle[a]) + term[a];
                if (s > ACC_MAX)
                    s = ACC_MAX;
                if (s < ACC_MIN)
                    s = ACC_MIN;
                axis_angle[a] = imu_tilt_pkg::GYRO_W'(s);
                word[a] = axis_angle[a];
            end
            else
                word[a] = imu_tilt_pkg::GYRO_W'(term[a]);
        end
        r.rate_x = word[0];
        r.rate_y = word[1];
        r.rate_z = word[2];
        return r;
    endfunction

    task automatic check_field(input string field, input longint want, input longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            errs++;
        end
    endtask

    // register writes, result compare, then sample prediction
    always @(posedge clk or negedge rst_n)
    begin : watch
        tilt_result_t want;
        if (!rst_n)
        begin
            mode_q        = imu_tilt_pkg::GYRO_MODE_INTEGRATE;
            gain_q        = imu_tilt_pkg::GAIN_RESET;
            axis_angle[0] = '0;
            axis_angle[1] = '0;
            axis_angle[2] = '0;
            expected_tilt.delete();
            errs = 0;
            mismatch_count <= 0;
            tilt_pending   <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    imu_tilt_pkg::CFG_IDX_MODE: mode_q = cfg_data[0];
                    imu_tilt_pkg::CFG_IDX_GAIN: gain_q = cfg_data;
                    default: ;
                endcase
            end

            if (out_valid && !out_stall)
            begin
                if (expected_tilt.size() == 0)
                begin
                    $error("result beat with no sample outstanding");
                    errs++;
                end
                else
                begin
                    want = expected_tilt.pop_front();
                    check_field("accel_roll", want.roll, accel_roll);
                    check_field("accel_pitch", want.pitch, accel_pitch);
                    check_field("gyro_roll", want.rate_x, gyro_roll);
                    check_field("gyro_pitch", want.rate_y, gyro_pitch);
                    check_field("gyro_yaw", want.rate_z, gyro_yaw);
                end
            end

            if (in_valid && !in_stall)
                expected_tilt.push_back(predict_tilt(accel_x, accel_y, accel_z,
                                                     gyro_x, gyro_y, gyro_z));

            mismatch_count <= errs;
            tilt_pending   <= expected_tilt.size();
        end
    end

endmodule

>>> tb/sv/imu_tilt_angle_estimator_unit_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tilt angle estimator testbench
// drives directed and random sample beats through the estimator under
// several gyro mode and gain settings, with random idling on both sides and
// one long result hold-off; a checker beside the block predicts every result
// ============================================================================
module imu_tilt_angle_estimator_unit_tb;

    localparam int STEPS = 16;
    localparam logic signed [imu_tilt_pkg::SAMPLE_W-1:0] S_MAX = 16'sh7fff;
    localparam logic signed [imu_tilt_pkg::SAMPLE_W-1:0] S_MIN = 16'sh8000;

    logic                                      clk;
    logic                                      rst_n;
    logic                                      in_valid;
    logic                                      in_stall;
    logic signed [imu_tilt_pkg::SAMPLE_W-1:0]  accel_x, accel_y, accel_z;
    logic signed [imu_tilt_pkg::SAMPLE_W-1:0]  gyro_x, gyro_y, gyro_z;
    logic                                      out_valid;
    logic                                      out_stall;
    logic signed [imu_tilt_pkg::ANGLE_W-1:0]   accel_roll, accel_pitch;
    logic signed [imu_tilt_pkg::GYRO_W-1:0]    gyro_roll, gyro_pitch, gyro_yaw;
    logic                                      cfg_valid;
    logic                                      cfg_ready;
    logic [imu_tilt_pkg::CFG_IDX_W-1:0]        cfg_index;
    logic [imu_tilt_pkg::GAIN_W-1:0]           cfg_data;

    int  mismatch_count;
    int  tilt_pending;
    bit  tx_gaps;
    bit  rx_gaps;
    bit  hold_armed;

    imu_tilt_angle_estimator_unit #(
        .CORDIC_STEPS (STEPS)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .accel_x     (accel_x),
        .accel_y     (accel_y),
        .accel_z     (accel_z),
        .gyro_x      (gyro_x),
        .gyro_y      (gyro_y),
        .gyro_z      (gyro_z),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .accel_roll  (accel_roll),
        .accel_pitch (accel_pitch),
        .gyro_roll   (gyro_roll),
        .gyro_pitch  (gyro_pitch),
        .gyro_yaw    (gyro_yaw),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    tilt_result_checker #(
        .CORDIC_STEPS (STEPS)
    ) result_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .accel_x        (accel_x),
        .accel_y        (accel_y),
        .accel_z        (accel_z),
        .gyro_x         (gyro_x),
        .gyro_y         (gyro_y),
        .gyro_z         (gyro_z),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .accel_roll     (accel_roll),
        .accel_pitch    (accel_pitch),
        .gyro_roll      (gyro_roll),
        .gyro_pitch     (gyro_pitch),
        .gyro_yaw       (gyro_yaw),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .tilt_pending   (tilt_pending)
    );

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // hard limit on run length
    initial
    begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // result side: random stall bursts, one long hold-off when armed
    initial
    begin : result_side
        int stall_left;
        bit hold_done;
        stall_left = 0;
        hold_done  = 1'b0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_armed && !hold_done)
            begin
                hold_done  = 1'b1;
                stall_left = 400;
            end
            else if (stall_left == 0 && rx_gaps && $urandom_range(0, 4) == 0)
                stall_left = $urandom_range(1, 9);
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // accelerometer axis mix: zero, extremes, near zero, full range
    function automatic logic signed [imu_tilt_pkg::SAMPLE_W-1:0] pick_axis();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return S_MAX;
            2:       return S_MIN;
            3, 4:    return imu_tilt_pkg::SAMPLE_W'(int'($urandom_range(0, 200)) - 100);
            default: return imu_tilt_pkg::SAMPLE_W'($urandom);
        endcase
    endfunction

    // one sample beat, held until taken
    task automatic offer_sample(
        input logic signed [imu_tilt_pkg::SAMPLE_W-1:0] ax, ay, az, gx, gy, gz
    );
        if (tx_gaps && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid <= 1'b1;
        accel_x  <= ax;
        accel_y  <= ay;
        accel_z  <= az;
        gyro_x   <= gx;
        gyro_y   <= gy;
        gyro_z   <= gz;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic offer_random(input int n);
        repeat (n)
            offer_sample(pick_axis(), pick_axis(), pick_axis(),
                         imu_tilt_pkg::SAMPLE_W'($urandom),
                         imu_tilt_pkg::SAMPLE_W'($urandom),
                         imu_tilt_pkg::SAMPLE_W'($urandom));
    endtask

    // register write, only with the block idle
    task automatic write_reg(input logic [imu_tilt_pkg::CFG_IDX_W-1:0] idx,
                             input logic [imu_tilt_pkg::GAIN_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // wait for every outstanding result, then let the block settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tilt_pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // stimulus
    initial
    begin : stimulus
        int     p;
        logic [imu_tilt_pkg::GAIN_W-1:0] g;
        logic signed [imu_tilt_pkg::SAMPLE_W-1:0] push;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        accel_x    <= '0;
        accel_y    <= '0;
        accel_z    <= '0;
        gyro_x     <= '0;
        gyro_y     <= '0;
        gyro_z     <= '0;
        cfg_valid  <= 1'b0;
        cfg_index  <= imu_tilt_pkg::CFG_IDX_MODE;
        cfg_data   <= '0;
        tx_gaps     = 1'b1;
        rx_gaps     = 1'b1;
        hold_armed  = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings, integrating
        offer_sample(0, 0, 0, 0, 0, 0);
        offer_sample(S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX);
        offer_sample(S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN);
        offer_sample(0, 0, -16'sd1000, -16'sd1, 16'sd1, 0);
        offer_sample(16'sd3, -16'sd1, S_MIN, S_MAX, S_MIN, -16'sd1);
        offer_sample(-16'sd5, 16'sd5, S_MIN, 0, 0, 0);
        offer_sample(S_MIN, S_MAX, 0, 16'sd511, -16'sd511, 16'sd512);
        offer_sample(16'sd1, S_MIN, 0, 0, 0, 0);
        offer_sample(S_MAX, S_MIN, 16'sd1, 0, 0, 0);
        offer_sample(S_MAX, S_MIN, S_MIN, S_MIN, S_MAX, S_MIN);
        offer_sample(S_MAX, S_MAX, -16'sd1, 0, 0, 0);
        offer_sample(0, 0, -16'sd1, 0, 0, 0);
        offer_sample(0, 16'sd1, 0, 0, 0, 0);
        offer_sample(-16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1);
        offer_sample(16'sd100, -16'sd100, 16'sd100, 16'sd129, -16'sd129, 16'sd1);
        offer_sample(-16'sd23170, 16'sd23170, -16'sd23170, 0, 0, 0);
        offer_random(120);

        // rate mode with random spare data bits, full gain
        wait_idle();
        write_reg(imu_tilt_pkg::CFG_IDX_MODE, {15'($urandom), imu_tilt_pkg::GYRO_MODE_RATE});
        write_reg(imu_tilt_pkg::CFG_IDX_GAIN, 16'hffff);
        offer_random(120);

        // unused register index, then zero gain in both modes
        wait_idle();
        write_reg(imu_tilt_pkg::CFG_IDX_W'($urandom_range(2, 15)),
                  imu_tilt_pkg::GAIN_W'($urandom));
        write_reg(imu_tilt_pkg::CFG_IDX_W'($urandom_range(2, 15)),
                  imu_tilt_pkg::GAIN_W'($urandom));
        write_reg(imu_tilt_pkg::CFG_IDX_GAIN, '0);
        offer_random(60);
        wait_idle();
        write_reg(imu_tilt_pkg::CFG_IDX_MODE,
                  {15'($urandom), imu_tilt_pkg::GYRO_MODE_INTEGRATE});
        offer_random(60);

        // integrate at full gain until the roll and pitch accumulators saturate, then back off
        wait_idle();
        write_reg(imu_tilt_pkg::CFG_IDX_GAIN, 16'hffff);
        repeat (580)
        begin
            push = imu_tilt_pkg::SAMPLE_W'($urandom_range(30000, 32767));
            offer_sample(pick_axis(), pick_axis(), pick_axis(), push, -push,
                         $urandom_range(0, 1) ? S_MAX : S_MIN);
        end
        repeat (40)
        begin
            push = imu_tilt_pkg::SAMPLE_W'($urandom_range(20000, 32767));
            offer_sample(pick_axis(), pick_axis(), pick_axis(), -push, push,
                         imu_tilt_pkg::SAMPLE_W'($urandom));
        end

        // random settings, long result hold-off in the middle
        for (p = 0; p < 5; p++)
        begin
            wait_idle();
            case ($urandom_range(0, 2))
                0:       g = 16'd1;
                1:       g = 16'hffff;
                default: g = imu_tilt_pkg::GAIN_W'($urandom);
            endcase
            write_reg(imu_tilt_pkg::CFG_IDX_GAIN, g);
            write_reg(imu_tilt_pkg::CFG_IDX_MODE, imu_tilt_pkg::GAIN_W'($urandom));
            if (p == 2)
                hold_armed = 1'b1;
            offer_random(90);
        end

        // last stretch with no idling
        wait_idle();
        write_reg(imu_tilt_pkg::CFG_IDX_MODE,
                  {15'($urandom), imu_tilt_pkg::GYRO_MODE_INTEGRATE});
        write_reg(imu_tilt_pkg::CFG_IDX_GAIN, imu_tilt_pkg::GAIN_RESET);
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        offer_random(150);

        wait_idle();
        repeat (60) @(posedge clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/imu_tilt_pkg.sv
hw/rtl/imu_tilt_cordic.sv
hw/rtl/imu_tilt_gyro.sv
hw/rtl/imu_tilt_angle_estimator_unit.sv
tb/sv/tilt_result_checker.sv
tb/sv/imu_tilt_angle_estimator_unit_tb.sv
